// ===== sv/btha_pkg.sv =====
`default_nettype none
package btha_pkg;

  // Field widths of the request and result beats.
  localparam int unsigned OP_W    = 3;
  localparam int unsigned LEN_W   = 15;
  localparam int unsigned FIELD_W = 11;
  localparam int unsigned STAT_W  = 2;
  localparam int unsigned DIV_W   = 16;

  // Smallest heap that a rebuild accepts.
  localparam int unsigned MIN_BLOCKS = 21;

  // Request codes.
  localparam logic [OP_W-1:0] OP_ALLOC   = 3'd0;
  localparam logic [OP_W-1:0] OP_FREE    = 3'd1;
  localparam logic [OP_W-1:0] OP_DEFRAG  = 3'd2;
  localparam logic [OP_W-1:0] OP_ANALYSE = 3'd3;
  localparam logic [OP_W-1:0] OP_REINIT  = 3'd4;

  // Status codes.
  localparam logic [STAT_W-1:0] ST_OK       = 2'd0;
  localparam logic [STAT_W-1:0] ST_NO_FIT   = 2'd1;
  localparam logic [STAT_W-1:0] ST_BAD_LEN  = 2'd2;
  localparam logic [STAT_W-1:0] ST_BAD_ADDR = 2'd3;

  // Configuration register indexes.
  localparam logic CFG_HEAP_BLOCKS = 1'b0;
  localparam logic CFG_MERGE       = 1'b1;

endpackage
`default_nettype wire

// ===== sv/boundary_tag_heap_allocator.sv =====
`default_nettype none
// First-fit heap allocator with one-block boundary tags kept in a single
// synchronous RAM word per block (tag present, allocated, size after, size
// before). Requests are served one at a time by a sequencer that reads,
// modifies and writes that RAM. An allocate divides the length into
// blocks, walks the tags from the lowest free tag, writes the split and
// granted tags and, if it took the lowest free tag, moves the lowest-free
// pointer on. A free checks the tag, releases the region and, with merging
// on, merges it with free neighbours. Defragment walks the tags and folds
// runs of free regions, analyse walks the tags. Reinitialize, and the time
// after reset before the first request is taken, is a clearing pass over
// HEAP_MAX_BLOCKS+1 words. Configuration writes take effect at once,
// the heap size at the next reinitialize.
module boundary_tag_heap_allocator #(
  parameter int unsigned HEAP_MAX_BLOCKS = 1024,
  parameter int unsigned BLOCK_BYTES     = 16
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              cfg_we_i,
  input  wire logic                              cfg_index_i,
  input  wire logic [btha_pkg::FIELD_W-1:0]      cfg_wdata_i,
  input  wire logic                              in_valid_i,
  output logic                                   in_ready_o,
  input  wire logic [btha_pkg::OP_W-1:0]         operation_i,
  input  wire logic [btha_pkg::LEN_W-1:0]        length_bytes_i,
  input  wire logic [btha_pkg::FIELD_W-1:0]      data_block_i,
  output logic                                   out_valid_o,
  input  wire logic                              out_ready_i,
  output logic      [btha_pkg::STAT_W-1:0]       status_o,
  output logic      [btha_pkg::FIELD_W-1:0]      granted_block_o,
  output logic      [btha_pkg::FIELD_W-1:0]      free_total_o,
  output logic      [btha_pkg::FIELD_W-1:0]      used_total_o,
  output logic      [btha_pkg::FIELD_W-1:0]      largest_free_o,
  output logic      [btha_pkg::FIELD_W-1:0]      tag_count_o
);

  localparam int unsigned DEPTH = HEAP_MAX_BLOCKS + 1;
  localparam int unsigned PW    = $clog2(DEPTH);
  localparam int unsigned AW    = (PW + 1 > 16) ? PW + 1 : 16;
  localparam int unsigned EW    = 2 + 2 * PW;
  localparam int unsigned FW    = btha_pkg::FIELD_W;
  localparam int unsigned DW    = btha_pkg::DIV_W;
  localparam int unsigned RST_END = (HEAP_MAX_BLOCKS < 1024) ? HEAP_MAX_BLOCKS : 1024;

  typedef enum logic [28:0] {
    S_CLR    = 29'd1 << 0,
    S_IDLE   = 29'd1 << 1,
    S_FIN    = 29'd1 << 2,
    S_DIV    = 29'd1 << 3,
    S_ARD    = 29'd1 << 4,
    S_ACHK   = 29'd1 << 5,
    S_AWAFT  = 29'd1 << 6,
    S_AWNT   = 29'd1 << 7,
    S_AWCUR  = 29'd1 << 8,
    S_LRD    = 29'd1 << 9,
    S_LCHK   = 29'd1 << 10,
    S_FRD    = 29'd1 << 11,
    S_FCHK   = 29'd1 << 12,
    S_FNX    = 29'd1 << 13,
    S_FBEY   = 29'd1 << 14,
    S_FWCUR  = 29'd1 << 15,
    S_PSTART = 29'd1 << 16,
    S_PCHK   = 29'd1 << 17,
    S_PNX    = 29'd1 << 18,
    S_PWPV   = 29'd1 << 19,
    S_PWCUR  = 29'd1 << 20,
    S_DTOP   = 29'd1 << 21,
    S_DCURL  = 29'd1 << 22,
    S_DNXL   = 29'd1 << 23,
    S_DEVAL  = 29'd1 << 24,
    S_DNX2L  = 29'd1 << 25,
    S_DWFIN  = 29'd1 << 26,
    S_NTOP   = 29'd1 << 27,
    S_NL     = 29'd1 << 28
  } state_e;

  state_e state_q, state_d;

  // Configuration and heap-wide registers.
  logic [FW-1:0] heap_blocks_q, heap_blocks_d;
  logic          merge_q, merge_d;
  logic [PW-1:0] end_q, end_d;
  logic [PW-1:0] low_q, low_d;
  logic          fin_clr_q, fin_clr_d;
  logic [PW-1:0] clr_q, clr_d;

  // Request working registers.
  logic [btha_pkg::OP_W-1:0] op_q, op_d;
  logic [PW-1:0] cur_q, cur_d;
  logic [PW-1:0] aux_q, aux_d;
  logic [PW-1:0] nx_q, nx_d;
  logic [PW-1:0] n_q, n_d;
  logic [PW-1:0] new_q, new_d;
  logic          ctag_q, ctag_d;
  logic          calloc_q, calloc_d;
  logic [PW-1:0] csa_q, csa_d;
  logic [PW-1:0] csb_q, csb_d;
  logic [PW-1:0] psb_q, psb_d;
  logic          nalloc_q, nalloc_d;
  logic [PW-1:0] nsa_q, nsa_d;

  // Result being built and the output register.
  logic [btha_pkg::STAT_W-1:0] rstat_q, rstat_d;
  logic [FW-1:0] rgrant_q, rgrant_d;
  logic [PW-1:0] fr_q, fr_d;
  logic [PW-1:0] us_q, us_d;
  logic [PW-1:0] big_q, big_d;
  logic [PW-1:0] cnt_q, cnt_d;
  logic          out_valid_q, out_valid_d;
  logic [btha_pkg::STAT_W-1:0] ostat_q, ostat_d;
  logic [FW-1:0] ogrant_q, ogrant_d;
  logic [FW-1:0] ofr_q, ofr_d;
  logic [FW-1:0] ous_q, ous_d;
  logic [FW-1:0] obig_q, obig_d;
  logic [FW-1:0] ocnt_q, ocnt_d;

  // Memory port.
  logic          we;
  logic [PW-1:0] waddr;
  logic [EW-1:0] wdata;
  logic [PW-1:0] raddr;
  logic [EW-1:0] rdata;
  logic          rd_tag;
  logic          rd_alloc;
  logic [PW-1:0] rd_sa;
  logic [PW-1:0] rd_sb;

  // Length divider.
  logic          div_start;
  logic          div_done;
  logic [DW-1:0] div_quo;
  logic [DW-1:0] div_in;

  // Temporaries of the sequencer.
  logic [AW-1:0] hb_ext;
  logic [AW-1:0] clamp_end;
  logic [AW-1:0] nxt_rd;
  logic [AW-1:0] nxt_cs;
  logic [AW-1:0] db_m1;
  logic [PW-1:0] merged;

  btha_ram #(
    .WIDTH(EW),
    .DEPTH(DEPTH)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(waddr),
    .wdata_i(wdata),
    .raddr_i(raddr),
    .rdata_o(rdata)
  );

  btha_div #(
    .WIDTH  (DW),
    .DIVISOR(BLOCK_BYTES)
  ) u_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (div_start),
    .dividend_i(div_in),
    .done_o    (div_done),
    .quotient_o(div_quo)
  );

  // Fields of the word that was read.
  assign rd_tag   = rdata[EW-1];
  assign rd_alloc = rdata[EW-2];
  assign rd_sa    = rdata[2*PW-1:PW];
  assign rd_sb    = rdata[PW-1:0];

  assign div_in = DW'(length_bytes_i) + DW'(BLOCK_BYTES - 1);

  // Heap end taken at a rebuild, saturated to the supported range.
  assign hb_ext    = AW'(heap_blocks_q);
  assign clamp_end = (hb_ext < AW'(btha_pkg::MIN_BLOCKS)) ? AW'(btha_pkg::MIN_BLOCKS) :
                     (hb_ext > AW'(HEAP_MAX_BLOCKS)) ? AW'(HEAP_MAX_BLOCKS) : hb_ext;

  // Next tag after the current one, from the word read and from the register.
  assign nxt_rd = AW'(cur_q) + AW'(rd_sa) + AW'(1);
  assign nxt_cs = AW'(cur_q) + AW'(csa_q) + AW'(1);
  assign db_m1  = AW'(data_block_i) - AW'(1);
  assign merged = csa_q + nsa_q + PW'(1);

  assign in_ready_o = (state_q == S_IDLE);

  always_comb begin
    state_d       = state_q;
    heap_blocks_d = heap_blocks_q;
    merge_d       = merge_q;
    end_d         = end_q;
    low_d         = low_q;
    fin_clr_d     = fin_clr_q;
    clr_d         = clr_q;
    op_d          = op_q;
    cur_d         = cur_q;
    aux_d         = aux_q;
    nx_d          = nx_q;
    n_d           = n_q;
    new_d         = new_q;
    ctag_d        = ctag_q;
    calloc_d      = calloc_q;
    csa_d         = csa_q;
    csb_d         = csb_q;
    psb_d         = psb_q;
    nalloc_d      = nalloc_q;
    nsa_d         = nsa_q;
    rstat_d       = rstat_q;
    rgrant_d      = rgrant_q;
    fr_d          = fr_q;
    us_d          = us_q;
    big_d         = big_q;
    cnt_d         = cnt_q;
    out_valid_d   = out_valid_q && !out_ready_i;
    ostat_d       = ostat_q;
    ogrant_d      = ogrant_q;
    ofr_d         = ofr_q;
    ous_d         = ous_q;
    obig_d        = obig_q;
    ocnt_d        = ocnt_q;
    we            = 1'b0;
    waddr         = cur_q;
    wdata         = '0;
    raddr         = cur_q;
    div_start     = 1'b0;

    // Configuration writes.
    if (cfg_we_i) begin
      unique case (cfg_index_i)
        btha_pkg::CFG_HEAP_BLOCKS: heap_blocks_d = cfg_wdata_i;
        btha_pkg::CFG_MERGE:       merge_d = cfg_wdata_i[0];
        default: ;
      endcase
    end

    unique case (state_q)
      // Clearing pass: tags at zero and at the heap end, all else empty.
      S_CLR: begin
        we    = 1'b1;
        waddr = clr_q;
        if (clr_q == '0) begin
          wdata = {1'b1, 1'b0, end_q - PW'(1), {PW{1'b1}}};
        end else if (clr_q == end_q) begin
          wdata = {1'b1, 1'b0, PW'(0), end_q - PW'(1)};
        end
        clr_d = clr_q + PW'(1);
        if (clr_q == PW'(HEAP_MAX_BLOCKS)) begin
          clr_d   = '0;
          state_d = fin_clr_q ? S_FIN : S_IDLE;
        end
      end

      // Take a request beat and dispatch it.
      S_IDLE: begin
        if (in_valid_i) begin
          op_d     = operation_i;
          rstat_d  = btha_pkg::ST_OK;
          rgrant_d = '0;
          fr_d     = '0;
          us_d     = '0;
          big_d    = '0;
          cnt_d    = '0;
          cur_d    = '0;
          case (operation_i)
            btha_pkg::OP_ALLOC: begin
              div_start = 1'b1;
              state_d   = S_DIV;
            end
            btha_pkg::OP_FREE: begin
              if (data_block_i == '0 || db_m1 >= AW'(end_q)) begin
                rstat_d = btha_pkg::ST_BAD_ADDR;
                state_d = S_FIN;
              end else begin
                cur_d   = db_m1[PW-1:0];
                state_d = S_FRD;
              end
            end
            btha_pkg::OP_DEFRAG:  state_d = S_DTOP;
            btha_pkg::OP_ANALYSE: state_d = S_NTOP;
            btha_pkg::OP_REINIT: begin
              end_d     = clamp_end[PW-1:0];
              low_d     = '0;
              clr_d     = '0;
              fin_clr_d = 1'b1;
              state_d   = S_CLR;
            end
            default: state_d = S_FIN;
          endcase
        end
      end

      // Hand the result to the output register.
      S_FIN: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d = 1'b1;
          ostat_d     = rstat_q;
          ogrant_d    = rgrant_q;
          ofr_d       = FW'(fr_q);
          ous_d       = FW'(us_q);
          obig_d      = FW'(big_q);
          ocnt_d      = FW'(cnt_q);
          fin_clr_d   = 1'b0;
          state_d     = S_IDLE;
        end
      end

      // Allocate: length in blocks, then first-fit walk.
      S_DIV: begin
        if (div_done) begin
          if (div_quo == '0 || AW'(div_quo) >= AW'(end_q)) begin
            rstat_d = btha_pkg::ST_BAD_LEN;
            state_d = S_FIN;
          end else begin
            n_d     = div_quo[PW-1:0];
            cur_d   = low_q;
            state_d = S_ARD;
          end
        end
      end

      S_ARD: begin
        if (cur_q >= end_q) begin
          rstat_d = btha_pkg::ST_NO_FIT;
          state_d = S_FIN;
        end else begin
          raddr   = cur_q;
          state_d = S_ACHK;
        end
      end

      S_ACHK: begin
        if (!rd_alloc && rd_sa >= n_q) begin
          ctag_d = rd_tag;
          csa_d  = rd_sa;
          csb_d  = rd_sb;
          if (rd_sa > n_q) begin
            aux_d   = nxt_rd[PW-1:0];
            raddr   = nxt_rd[PW-1:0];
            state_d = S_AWAFT;
          end else begin
            state_d = S_AWCUR;
          end
        end else begin
          cur_d   = nxt_rd[PW-1:0];
          state_d = S_ARD;
        end
      end

      // Split: tag after the region learns the size of the remainder.
      S_AWAFT: begin
        we      = 1'b1;
        waddr   = aux_q;
        wdata   = {rd_tag, rd_alloc, rd_sa, csa_q - n_q - PW'(1)};
        state_d = S_AWNT;
      end

      // Split: new free tag behind the granted blocks.
      S_AWNT: begin
        we      = 1'b1;
        waddr   = cur_q + n_q + PW'(1);
        wdata   = {1'b1, 1'b0, csa_q - n_q - PW'(1), n_q};
        state_d = S_AWCUR;
      end

      S_AWCUR: begin
        we       = 1'b1;
        waddr    = cur_q;
        wdata    = {ctag_q, 1'b1, (csa_q > n_q) ? n_q : csa_q, csb_q};
        rgrant_d = FW'(AW'(cur_q) + AW'(1));
        state_d  = (cur_q == low_q) ? S_LRD : S_FIN;
      end

      // Move the lowest-free pointer past allocated regions.
      S_LRD: begin
        raddr   = low_q;
        state_d = S_LCHK;
      end

      S_LCHK: begin
        if (!rd_alloc) begin
          state_d = S_FIN;
        end else if (AW'(low_q) + AW'(rd_sa) + AW'(1) >= AW'(end_q)) begin
          state_d = S_FIN;
        end else begin
          low_d   = low_q + rd_sa + PW'(1);
          state_d = S_LRD;
        end
      end

      // Free: check the tag and release the region.
      S_FRD: begin
        raddr   = cur_q;
        state_d = S_FCHK;
      end

      S_FCHK: begin
        if (!rd_tag || !rd_alloc) begin
          rstat_d = btha_pkg::ST_BAD_ADDR;
          state_d = S_FIN;
        end else begin
          we    = 1'b1;
          waddr = cur_q;
          wdata = {1'b1, 1'b0, rd_sa, rd_sb};
          csa_d = rd_sa;
          csb_d = rd_sb;
          if (low_q > cur_q) begin
            low_d = cur_q;
          end
          if (!merge_q) begin
            state_d = S_FIN;
          end else if (nxt_rd < AW'(end_q)) begin
            aux_d   = nxt_rd[PW-1:0];
            raddr   = nxt_rd[PW-1:0];
            state_d = S_FNX;
          end else begin
            state_d = S_PSTART;
          end
        end
      end

      // Merge with the free region that follows.
      S_FNX: begin
        if (!rd_alloc) begin
          csa_d   = csa_q + rd_sa + PW'(1);
          we      = 1'b1;
          waddr   = aux_q;
          wdata   = '0;
          raddr   = aux_q + rd_sa + PW'(1);
          aux_d   = aux_q + rd_sa + PW'(1);
          state_d = S_FBEY;
        end else begin
          state_d = S_PSTART;
        end
      end

      S_FBEY: begin
        we      = 1'b1;
        waddr   = aux_q;
        wdata   = {rd_tag, rd_alloc, rd_sa, csa_q};
        state_d = S_FWCUR;
      end

      S_FWCUR: begin
        we      = 1'b1;
        waddr   = cur_q;
        wdata   = {1'b1, 1'b0, csa_q, csb_q};
        state_d = S_PSTART;
      end

      // Merge with the free region that precedes.
      S_PSTART: begin
        if (cur_q == '0) begin
          state_d = S_FIN;
        end else begin
          aux_d   = cur_q - csb_q - PW'(1);
          raddr   = cur_q - csb_q - PW'(1);
          state_d = S_PCHK;
        end
      end

      S_PCHK: begin
        if (rd_alloc) begin
          state_d = S_FIN;
        end else begin
          psb_d   = rd_sb;
          ctag_d  = rd_tag;
          nx_d    = nxt_cs[PW-1:0];
          raddr   = nxt_cs[PW-1:0];
          state_d = S_PNX;
        end
      end

      S_PNX: begin
        new_d   = rd_sb + csb_q + PW'(1);
        we      = 1'b1;
        waddr   = nx_q;
        wdata   = {rd_tag, rd_alloc, rd_sa, rd_sb + csb_q + PW'(1)};
        state_d = S_PWPV;
      end

      S_PWPV: begin
        we      = 1'b1;
        waddr   = aux_q;
        wdata   = {ctag_q, 1'b0, new_q, psb_q};
        state_d = S_PWCUR;
      end

      S_PWCUR: begin
        we      = 1'b1;
        waddr   = cur_q;
        wdata   = '0;
        state_d = S_FIN;
      end

      // Defragment: walk the chain and fold runs of free regions.
      S_DTOP: begin
        if (cur_q >= end_q) begin
          state_d = S_FIN;
        end else begin
          raddr   = cur_q;
          state_d = S_DCURL;
        end
      end

      S_DCURL: begin
        ctag_d   = rd_tag;
        calloc_d = rd_alloc;
        csa_d    = rd_sa;
        csb_d    = rd_sb;
        if (nxt_rd >= AW'(end_q)) begin
          state_d = S_FIN;
        end else begin
          nx_d    = nxt_rd[PW-1:0];
          raddr   = nxt_rd[PW-1:0];
          state_d = S_DNXL;
        end
      end

      S_DNXL: begin
        nalloc_d = rd_alloc;
        nsa_d    = rd_sa;
        state_d  = S_DEVAL;
      end

      S_DEVAL: begin
        if (!calloc_q && !nalloc_q) begin
          csa_d   = merged;
          we      = 1'b1;
          waddr   = nx_q;
          wdata   = '0;
          nx_d    = cur_q + merged + PW'(1);
          raddr   = cur_q + merged + PW'(1);
          state_d = S_DNX2L;
        end else begin
          we      = 1'b1;
          waddr   = cur_q;
          wdata   = {ctag_q, calloc_q, csa_q, csb_q};
          cur_d   = nx_q;
          state_d = S_DTOP;
        end
      end

      S_DNX2L: begin
        we       = 1'b1;
        waddr    = nx_q;
        wdata    = {rd_tag, rd_alloc, rd_sa, csa_q};
        nalloc_d = rd_alloc;
        nsa_d    = rd_sa;
        state_d  = (nx_q >= end_q) ? S_DWFIN : S_DEVAL;
      end

      S_DWFIN: begin
        we      = 1'b1;
        waddr   = cur_q;
        wdata   = {ctag_q, calloc_q, csa_q, csb_q};
        state_d = S_FIN;
      end

      // Analyse: accumulate totals along the chain.
      S_NTOP: begin
        if (cur_q >= end_q) begin
          state_d = S_FIN;
        end else begin
          raddr   = cur_q;
          state_d = S_NL;
        end
      end

      S_NL: begin
        if (rd_alloc) begin
          us_d = us_q + rd_sa;
        end else begin
          fr_d = fr_q + rd_sa;
          if (rd_sa > big_q) begin
            big_d = rd_sa;
          end
        end
        cnt_d   = cnt_q + PW'(1);
        cur_d   = nxt_rd[PW-1:0];
        state_d = S_NTOP;
      end

      default: state_d = S_IDLE;
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= S_CLR;
      heap_blocks_q <= FW'(1024);
      merge_q       <= 1'b1;
      end_q         <= PW'(RST_END);
      low_q         <= '0;
      fin_clr_q     <= 1'b0;
      clr_q         <= '0;
      out_valid_q   <= 1'b0;
    end else begin
      state_q       <= state_d;
      heap_blocks_q <= heap_blocks_d;
      merge_q       <= merge_d;
      end_q         <= end_d;
      low_q         <= low_d;
      fin_clr_q     <= fin_clr_d;
      clr_q         <= clr_d;
      out_valid_q   <= out_valid_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    op_q     <= op_d;
    cur_q    <= cur_d;
    aux_q    <= aux_d;
    nx_q     <= nx_d;
    n_q      <= n_d;
    new_q    <= new_d;
    ctag_q   <= ctag_d;
    calloc_q <= calloc_d;
    csa_q    <= csa_d;
    csb_q    <= csb_d;
    psb_q    <= psb_d;
    nalloc_q <= nalloc_d;
    nsa_q    <= nsa_d;
    rstat_q  <= rstat_d;
    rgrant_q <= rgrant_d;
    fr_q     <= fr_d;
    us_q     <= us_d;
    big_q    <= big_d;
    cnt_q    <= cnt_d;
    ostat_q  <= ostat_d;
    ogrant_q <= ogrant_d;
    ofr_q    <= ofr_d;
    ous_q    <= ous_d;
    obig_q   <= obig_d;
    ocnt_q   <= ocnt_d;
  end

  assign out_valid_o     = out_valid_q;
  assign status_o        = ostat_q;
  assign granted_block_o = ogrant_q;
  assign free_total_o    = ofr_q;
  assign used_total_o    = ous_q;
  assign largest_free_o  = obig_q;
  assign tag_count_o     = ocnt_q;

endmodule
`default_nettype wire

// ===== sv/btha_ram.sv =====
`default_nettype none
module btha_ram #(
  parameter int unsigned WIDTH = 24,
  parameter int unsigned DEPTH = 1025
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // One write port and one registered read port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule
`default_nettype wire

// ===== sv/btha_div.sv =====
`default_nettype none
module btha_div #(
  parameter int unsigned WIDTH   = 16,
  parameter int unsigned DIVISOR = 16
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             start_i,
  input  wire logic [WIDTH-1:0] dividend_i,
  output logic                  done_o,
  output logic      [WIDTH-1:0] quotient_o
);

  localparam int unsigned SH  = WIDTH + $clog2(DIVISOR);
  localparam int unsigned PRW = SH + WIDTH;
  localparam longint unsigned MUL = ((64'd1 << SH) + 64'(DIVISOR) - 64'd1) / 64'(DIVISOR);

  logic             done_q;
  logic [WIDTH-1:0] quo_q;
  logic [PRW-1:0]   prod;

  // Multiply by the reciprocal rounded up; the error stays below one
  // quotient step for every dividend of WIDTH bits.
  assign prod = PRW'(dividend_i) * PRW'(MUL);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= start_i;
    end
  end

  // Quotient register, loaded at start.
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= prod[SH +: WIDTH];
    end
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule
`default_nettype wire

// ===== tb/testbench.sv =====
`timescale 1ns / 100ps
module testbench;

  localparam int unsigned MAX_BLK   = 1024;
  localparam int unsigned BLK_BYTES = 16;
  localparam int unsigned NO_PREV   = 11'h7FF;
  localparam int unsigned STALL_MAX = 60000;

  typedef logic [btha_pkg::FIELD_W-1:0] fld_t;
  typedef logic [btha_pkg::OP_W-1:0]    op_t;
  typedef logic [btha_pkg::LEN_W-1:0]   len_t;
  typedef logic [btha_pkg::STAT_W-1:0]  stat_t;

  typedef struct packed {
    stat_t status;
    fld_t  granted;
    fld_t  free_sum;
    fld_t  used_sum;
    fld_t  largest;
    fld_t  tags;
  } heap_result_t;

  typedef struct {
    op_t          op;
    len_t         len;
    fld_t         blk;
    bit           typed;
    heap_result_t res;
  } heap_req_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic cfg_index_i = 1'b0;
  fld_t cfg_wdata_i = '0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  op_t  operation_i = '0;
  len_t length_bytes_i = '0;
  fld_t data_block_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  stat_t status_o;
  fld_t granted_block_o, free_total_o, used_total_o, largest_free_o, tag_count_o;

  // Side-band data that travels with the request beat.
  bit           req_typed = 1'b0;
  heap_result_t req_res = '0;

  boundary_tag_heap_allocator DUT (.*);

  always #5 clk_i = ~clk_i;

  // Shadow heap state.
  bit          shadow_tag[0:MAX_BLK];
  bit          shadow_used[0:MAX_BLK];
  int unsigned shadow_after[0:MAX_BLK];
  int unsigned shadow_before[0:MAX_BLK];
  int unsigned shadow_low;
  int unsigned shadow_end;
  int unsigned shadow_heap_cfg = MAX_BLK;
  bit          shadow_merge = 1'b1;

  heap_result_t expected_results[$];
  fld_t         live_blocks[$];
  int           errors = 0;
  int           idle_cycles = 0;
  bit           quiet = 1'b0;
  bit           hold_go = 1'b0;
  int           hold_cnt = 0;

  function automatic void heap_rebuild();
    shadow_end = shadow_heap_cfg < btha_pkg::MIN_BLOCKS ? btha_pkg::MIN_BLOCKS :
                 shadow_heap_cfg > MAX_BLK ? MAX_BLK : shadow_heap_cfg;
    for (int i = 0; i <= MAX_BLK; i++) begin
      shadow_tag[i] = 0;
      shadow_used[i] = 0;
      shadow_after[i] = 0;
      shadow_before[i] = 0;
    end
    shadow_tag[0] = 1;
    shadow_tag[shadow_end] = 1;
    shadow_after[0] = shadow_end - 1;
    shadow_before[0] = NO_PREV;
    shadow_before[shadow_end] = shadow_end - 1;
    shadow_low = 0;
  endfunction

  function automatic int unsigned next_tag(int unsigned p);
    return p + shadow_after[p] + 1;
  endfunction

  // Computes the result of one request and updates the shadow heap.
  function automatic heap_result_t heap_apply(op_t op, len_t len, fld_t blk);
    heap_result_t r;
    int unsigned n, cur, guard, s, nx, beyond, prev, fr, us, big, cnt;
    r = '0;
    case (op)
      btha_pkg::OP_ALLOC: begin
        n = (int'(len) + BLK_BYTES - 1) / BLK_BYTES;
        cur = shadow_low;
        guard = 0;
        if (n == 0 || n >= shadow_end) begin
          r.status = btha_pkg::ST_BAD_LEN;
          return r;
        end
        while (cur < shadow_end && guard <= MAX_BLK) begin
          guard++;
          if (!shadow_used[cur] && shadow_after[cur] >= n) begin
            s = shadow_after[cur];
            if (s > n) begin
              shadow_before[cur + s + 1] = s - n - 1;
              shadow_tag[cur + n + 1] = 1;
              shadow_used[cur + n + 1] = 0;
              shadow_after[cur + n + 1] = s - n - 1;
              shadow_before[cur + n + 1] = n;
              shadow_after[cur] = n;
            end
            shadow_used[cur] = 1;
            // Advance the lowest-free pointer past allocated regions.
            if (cur == shadow_low) begin
              while (shadow_used[shadow_low]) begin
                nx = next_tag(shadow_low);
                if (nx >= shadow_end) break;
                shadow_low = nx;
              end
            end
            r.status = btha_pkg::ST_OK;
            r.granted = fld_t'(cur + 1);
            return r;
          end
          cur = next_tag(cur);
        end
        r.status = btha_pkg::ST_NO_FIT;
      end
      btha_pkg::OP_FREE: begin
        if (blk == 0 || blk - 1 >= shadow_end) begin
          r.status = btha_pkg::ST_BAD_ADDR;
          return r;
        end
        cur = blk - 1;
        if (!shadow_tag[cur] || !shadow_used[cur]) begin
          r.status = btha_pkg::ST_BAD_ADDR;
          return r;
        end
        shadow_used[cur] = 0;
        if (shadow_low > cur) shadow_low = cur;
        r.status = btha_pkg::ST_OK;
        if (!shadow_merge) return r;
        // Merge with the following free region.
        nx = next_tag(cur);
        if (nx < shadow_end && !shadow_used[nx]) begin
          beyond = next_tag(nx);
          shadow_after[cur] += shadow_after[nx] + 1;
          shadow_before[beyond] = shadow_after[cur];
          shadow_tag[nx] = 0;
          shadow_after[nx] = 0;
          shadow_before[nx] = 0;
        end
        // Merge into the preceding free region.
        if (cur != 0) begin
          prev = cur - shadow_before[cur] - 1;
          if (!shadow_used[prev]) begin
            nx = next_tag(cur);
            shadow_before[nx] += shadow_before[cur] + 1;
            shadow_after[prev] = shadow_before[nx];
            shadow_tag[cur] = 0;
            shadow_after[cur] = 0;
            shadow_before[cur] = 0;
          end
        end
      end
      btha_pkg::OP_DEFRAG: begin
        cur = 0;
        guard = 0;
        while (cur < shadow_end && guard <= MAX_BLK) begin
          guard++;
          nx = next_tag(cur);
          if (nx >= shadow_end) return r;
          while (!shadow_used[cur] && !shadow_used[nx]) begin
            shadow_after[cur] += shadow_after[nx] + 1;
            shadow_tag[nx] = 0;
            shadow_after[nx] = 0;
            shadow_before[nx] = 0;
            nx = next_tag(cur);
            shadow_before[nx] = shadow_after[cur];
            if (nx >= shadow_end) return r;
          end
          cur = nx;
        end
      end
      btha_pkg::OP_ANALYSE: begin
        cur = 0; fr = 0; us = 0; big = 0; cnt = 0;
        while (cur < shadow_end && cnt <= MAX_BLK) begin
          s = shadow_after[cur];
          if (shadow_used[cur]) us += s;
          else begin
            fr += s;
            if (s > big) big = s;
          end
          cnt++;
          cur = next_tag(cur);
        end
        r.free_sum = fld_t'(fr);
        r.used_sum = fld_t'(us);
        r.largest = fld_t'(big);
        r.tags = fld_t'(cnt);
      end
      btha_pkg::OP_REINIT: heap_rebuild();
      default: ;
    endcase
    return r;
  endfunction

  task automatic report_mismatch(string what, int unsigned got, int unsigned want);
    $display("mismatch at %0t: %s got %0d expected %0d", $time, what, got, want);
    errors++;
  endtask

  // Request and result monitor: predicts on each request beat, checks each result beat.
  always @(posedge clk_i) begin
    heap_result_t p, w;
    if (cfg_we_i) begin
      if (cfg_index_i == btha_pkg::CFG_HEAP_BLOCKS) shadow_heap_cfg = cfg_wdata_i;
      else shadow_merge = cfg_wdata_i[0];
    end
    if (in_valid_i && in_ready_o) begin
      p = heap_apply(operation_i, length_bytes_i, data_block_i);
      if (operation_i == btha_pkg::OP_ALLOC && p.status == btha_pkg::ST_OK)
        live_blocks.push_back(p.granted);
      if (operation_i == btha_pkg::OP_REINIT) live_blocks.delete();
      expected_results.push_back(req_typed ? req_res : p);
    end
    if (out_valid_o && out_ready_i) begin
      if (expected_results.size() == 0) begin
        report_mismatch("unexpected result beats", 1, 0);
      end else begin
        w = expected_results.pop_front();
        if (status_o !== w.status) report_mismatch("status", status_o, w.status);
        if (granted_block_o !== w.granted)
          report_mismatch("granted_block", granted_block_o, w.granted);
        if (free_total_o !== w.free_sum) report_mismatch("free_total", free_total_o, w.free_sum);
        if (used_total_o !== w.used_sum) report_mismatch("used_total", used_total_o, w.used_sum);
        if (largest_free_o !== w.largest)
          report_mismatch("largest_free", largest_free_o, w.largest);
        if (tag_count_o !== w.tags) report_mismatch("tag_count", tag_count_o, w.tags);
      end
    end
  end

  // Watchdog on cycles without any beat.
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) || !rst_ni) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_MAX) begin
      $display("FAIL");
      $finish;
    end
  end

  // Result receiver with random stalls and one long hold-off.
  always @(posedge clk_i) begin
    if (hold_go && hold_cnt < 400) begin
      hold_cnt <= hold_cnt + 1;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= quiet ? 1'b1 : ($urandom_range(0, 99) >= 19);
    end
  end

  task automatic send_beat(heap_req_t q);
    while (!quiet && $urandom_range(0, 99) < 19) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    operation_i <= q.op;
    length_bytes_i <= q.len;
    data_block_i <= q.blk;
    req_typed <= q.typed;
    req_res <= q.res;
    do @(posedge clk_i); while (!(in_valid_i && in_ready_o));
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  task automatic write_cfg(logic idx, fld_t val);
    cfg_we_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  function automatic heap_req_t mk(op_t op, int len, int blk, bit typed = 0,
                                   stat_t st = btha_pkg::ST_OK, int g = 0, int fr = 0,
                                   int us = 0, int big = 0, int cnt = 0);
    heap_req_t q;
    q.op = op;
    q.len = len_t'(len);
    q.blk = fld_t'(blk);
    q.typed = typed;
    q.res = '{st, fld_t'(g), fld_t'(fr), fld_t'(us), fld_t'(big), fld_t'(cnt)};
    return q;
  endfunction

  function automatic heap_req_t random_req();
    heap_req_t q;
    int r, k;
    q = mk(btha_pkg::OP_ANALYSE, $urandom_range(0, 32767), $urandom_range(0, 2047));
    r = $urandom_range(0, 99);
    if (r < 45) begin
      q.op = btha_pkg::OP_ALLOC;
      k = $urandom_range(0, 99);
      if (k < 80) q.len = len_t'($urandom_range(1, 8 * BLK_BYTES));
      else if (k < 88) q.len = len_t'($urandom_range(1, shadow_end * BLK_BYTES));
      else if (k < 92) q.len = '0;
    end else if (r < 80) begin
      q.op = btha_pkg::OP_FREE;
      if (live_blocks.size() != 0 && $urandom_range(0, 99) < 85) begin
        k = $urandom_range(0, live_blocks.size() - 1);
        q.blk = live_blocks[k];
        if ($urandom_range(0, 9) != 0) live_blocks.delete(k);
      end
    end else if (r < 88) q.op = btha_pkg::OP_DEFRAG;
    else if (r < 96) q.op = btha_pkg::OP_ANALYSE;
    else if (r < 98) q.op = btha_pkg::OP_REINIT;
    else q.op = op_t'($urandom_range(btha_pkg::OP_REINIT + 1, 7));
    return q;
  endfunction

  initial begin
    heap_req_t rows[$];
    int heaps[$];
    heap_rebuild();
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed checks on the default 1024-block heap with merging on.
    rows.push_back(mk(btha_pkg::OP_ANALYSE, 0, 0, 1, btha_pkg::ST_OK, 0, 1023, 0, 1023, 1));
    rows.push_back(mk(btha_pkg::OP_ALLOC, 0, 0, 1, btha_pkg::ST_BAD_LEN));
    rows.push_back(mk(btha_pkg::OP_ALLOC, 32767, 0, 1, btha_pkg::ST_BAD_LEN));
    rows.push_back(mk(btha_pkg::OP_ALLOC, 16384, 0, 1, btha_pkg::ST_BAD_LEN));
    rows.push_back(mk(btha_pkg::OP_ALLOC, 16, 2047, 1, btha_pkg::ST_OK, 1));
    rows.push_back(mk(btha_pkg::OP_FREE, 0, 0, 1, btha_pkg::ST_BAD_ADDR));
    rows.push_back(mk(btha_pkg::OP_FREE, 0, 2047, 1, btha_pkg::ST_BAD_ADDR));
    rows.push_back(mk(btha_pkg::OP_FREE, 0, 1025, 1, btha_pkg::ST_BAD_ADDR));
    rows.push_back(mk(btha_pkg::OP_FREE, 0, 5, 1, btha_pkg::ST_BAD_ADDR));
    rows.push_back(mk(btha_pkg::OP_FREE, 0, 1, 1, btha_pkg::ST_OK));
    rows.push_back(mk(btha_pkg::OP_FREE, 0, 1, 1, btha_pkg::ST_BAD_ADDR));
    rows.push_back(mk(btha_pkg::OP_ALLOC, 16368, 0, 1, btha_pkg::ST_OK, 1));
    rows.push_back(mk(btha_pkg::OP_ALLOC, 1, 0, 1, btha_pkg::ST_NO_FIT));
    rows.push_back(mk(btha_pkg::OP_ANALYSE, 0, 0, 1, btha_pkg::ST_OK, 0, 0, 1023, 0, 1));
    rows.push_back(mk(btha_pkg::OP_REINIT, 0, 0, 1, btha_pkg::ST_OK));
    rows.push_back(mk(btha_pkg::OP_ALLOC, 17, 0));
    rows.push_back(mk(btha_pkg::OP_ALLOC, 100, 0));
    rows.push_back(mk(btha_pkg::OP_ALLOC, 33, 0));
    rows.push_back(mk(btha_pkg::OP_FREE, 0, 4));
    rows.push_back(mk(btha_pkg::OP_FREE, 0, 1));
    rows.push_back(mk(btha_pkg::OP_DEFRAG, 0, 0));
    rows.push_back(mk(btha_pkg::OP_ANALYSE, 0, 0));
    rows.push_back(mk(3'd7, 0, 0, 1, btha_pkg::ST_OK));
    rows.push_back(mk(op_t'(btha_pkg::OP_REINIT + 1), 32767, 2047, 1, btha_pkg::ST_OK));
    foreach (rows[i]) send_beat(rows[i]);
    drain();

    // Random phases over several heap sizes, both merge settings.
    heaps = '{0, 2047, 21, 1024, 64, 150, 40, 300};
    foreach (heaps[ph]) begin
      write_cfg(btha_pkg::CFG_HEAP_BLOCKS, fld_t'(heaps[ph]));
      write_cfg(btha_pkg::CFG_MERGE,
                fld_t'(ph % 2 == 0 ? 1 : 0) | fld_t'($urandom_range(0, 1) << 1));
      quiet = (ph == 3);
      hold_go = (ph == 2);
      send_beat(mk(btha_pkg::OP_REINIT, 0, 0));
      repeat (105) send_beat(random_req());
      drain();
    end

    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
